[rtl/core/bsws_pkg.sv]
// shared types and constants for the bounded stack with search
package bsws_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned POS_W     = 6;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [WORD_W-1:0]  value;
    logic        [POS_W-1:0]   index;
  } in_beat_t;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  data;
    logic        [POS_W-1:0]   found_index;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic scan_end;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_start;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/bsws_ctrl.sv]
// sequencing state machine for the bounded stack with search
module bsws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bsws_pkg::dp_sts_t sts,
  output bsws_pkg::dp_cmd_t cmd
);
  import bsws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.accept    = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.scan_end  = 1'b0;
    cmd.load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.scan_start ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.scan_end = 1'b1;
          state_nxt    = S_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/bsws_dp.sv]
// entry memory, count, scan pointer and result register
module bsws_dp #(
  parameter int unsigned DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bsws_pkg::in_beat_t  in_beat,
  input  bsws_pkg::dp_cmd_t   cmd,
  output bsws_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output bsws_pkg::out_beat_t out_beat
);
  import bsws_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  cmd_t                 cmd_r;
  logic signed [WORD_W-1:0] key_r;
  status_t              status_r, status_nxt;
  logic [POS_W-1:0]     found_r, found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_beat_r;

  logic          is_full, is_empty, out_of_range;
  logic          hit, last;
  logic          mem_we, rd_en;
  logic [AW-1:0] rd_addr;

  assign is_full      = (count_r == CW'(DEPTH));
  assign is_empty     = (count_r == CW'(0));
  assign out_of_range = (CMPW'(in_beat.index) >= CMPW'(count_r));
  assign hit          = (rd_data_r == key_r);
  assign last         = ((CW'(ptr_r) + CW'(1)) == count_r);

  assign sts.scan_start = (in_beat.command == CMD_SEARCH) && !is_empty;
  assign sts.scan_done  = hit || last;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign mem_we = cmd.accept && (in_beat.command == CMD_PUSH) && !is_full;
  assign rd_en  = cmd.accept || cmd.scan_step;

  always_comb begin
    rd_addr = ptr_r + AW'(1);
    if (cmd.accept) begin
      case (in_beat.command)
        CMD_POP: rd_addr = AW'(count_r - CW'(1));
        CMD_GET: rd_addr = AW'(in_beat.index);
        default: rd_addr = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(count_r)] <= in_beat.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // status, count, scan pointer and found index update at accept and during the scan
  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    ptr_nxt    = ptr_r;
    if (cmd.accept) begin
      ptr_nxt   = '0;
      found_nxt = '0;
      case (in_beat.command)
        CMD_PUSH: begin
          status_nxt = is_full ? ST_FULL : ST_OK;
          if (!is_full) count_nxt = count_r + CW'(1);
        end
        CMD_POP: begin
          status_nxt = is_empty ? ST_EMPTY : ST_OK;
          if (!is_empty) count_nxt = count_r - CW'(1);
        end
        CMD_GET:    status_nxt = out_of_range ? ST_RANGE : ST_OK;
        CMD_SEARCH: status_nxt = is_empty ? ST_NOTFOUND : ST_OK;
        default:    status_nxt = ST_OK;
      endcase
    end else if (cmd.scan_step) begin
      ptr_nxt = ptr_r + AW'(1);
    end else if (cmd.scan_end) begin
      status_nxt = hit ? ST_OK : ST_NOTFOUND;
      found_nxt  = hit ? POS_W'(ptr_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    found_r  <= found_nxt;
    ptr_r    <= ptr_nxt;
    if (cmd.accept) begin
      cmd_r <= in_beat.command;
      key_r <= in_beat.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_beat_r.status      <= status_r;
      out_beat_r.found_index <= found_r;
      out_beat_r.data        <= ((status_r == ST_OK) &&
                                 ((cmd_r == CMD_POP) || (cmd_r == CMD_GET))) ?
                                rd_data_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && (in_beat.command == CMD_PUSH) && !is_full)
    |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the stack");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && (in_beat.command == CMD_POP) && !is_empty)
    |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not shrink the stack");

  a_err_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_beat_r.status != ST_OK)) |-> (out_beat_r.data == '0))
    else $error("failed request carries data");
`endif

endmodule

[rtl/core/bounded_stack_with_search.sv]
// top level of the bounded stack with indexed read and linear search
//
// in channel: one request beat (command, value, index) on in_valid/in_ready
// out channel: one result beat (status, data, found_index) per request on
//   out_valid/out_ready, in request order
// push, pop and get pass through idle (accept) and result (load the result
//   register); the entry memory read of pop and get lands in between
// search walks the entries from the bottom, one memory read per cycle, and
//   stops at the first hit or at the top entry; an empty stack skips the scan
// the single read port of the entry memory sets the search rate
// a new request is taken as soon as the controller is back in idle, even if
//   the previous result still sits unread in the output register
// if the receiver stalls with a result pending, the next finished result
//   waits in the datapath with the controller in result; no request is taken
// reset empties the stack and drops any pending result; memory contents are
//   not cleared, only entries below the count ever reach the output
module bounded_stack_with_search #(
  parameter int unsigned DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsws_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output bsws_pkg::out_beat_t out_beat
);
  import bsws_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle, scan, result
  bsws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, count, scan pointer and result register
  bsws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

[test/tb.sv]
// self-checking testbench for the bounded stack with indexed read and search
module tb;
  import bsws_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  // worst case is about 1300 beats, each a full-depth search plus long gaps and stalls
  localparam int CYCLE_LIMIT = 600000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  bounded_stack_with_search i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always #2 clk = ~clk;

  // shadow copy of the stack, advanced at each accepted request beat
  logic signed [WORD_W-1:0] stack_mem [STACK_DEPTH];
  int                       stack_fill = 0;
  out_beat_t                result_q [$];

  int err_count     = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  bit grow          = 1'b1;

  // expected result of one request, updates the shadow stack
  function automatic out_beat_t stack_predict(in_beat_t req);
    out_beat_t res;
    res = '0;
    res.status = ST_OK;
    case (req.command)
      CMD_PUSH: begin
        if (stack_fill == STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_mem[stack_fill] = req.value;
          stack_fill++;
        end
      end
      CMD_POP: begin
        if (stack_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          stack_fill--;
          res.data = stack_mem[stack_fill];
        end
      end
      CMD_GET: begin
        if (int'(req.index) >= stack_fill) begin
          res.status = ST_RANGE;
        end else begin
          res.data = stack_mem[req.index];
        end
      end
      default: begin
        // walk down so the lowest matching position wins
        res.status = ST_NOTFOUND;
        for (int i = stack_fill - 1; i >= 0; i--) begin
          if (stack_mem[i] == req.value) begin
            res.status      = ST_OK;
            res.found_index = POS_W'(i);
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic in_beat_t mk_req(cmd_t c, logic signed [WORD_W-1:0] v,
                                      logic [POS_W-1:0] ix);
    in_beat_t b;
    b.command = c;
    b.value   = v;
    b.index   = ix;
    return b;
  endfunction

  // keys drawn from the live stack hit often, small values give duplicates
  function automatic logic signed [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35 && stack_fill > 0) return stack_mem[$urandom_range(stack_fill - 1)];
    if (roll < 55) return $urandom_range(7);
    if (roll < 62) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic in_beat_t make_random_req();
    int               roll;
    cmd_t             c;
    logic [POS_W-1:0] ix;
    roll = $urandom_range(99);
    if (grow) begin
      if (roll < 45)      c = CMD_PUSH;
      else if (roll < 60) c = CMD_POP;
      else if (roll < 80) c = CMD_GET;
      else                c = CMD_SEARCH;
    end else begin
      if (roll < 15)      c = CMD_PUSH;
      else if (roll < 60) c = CMD_POP;
      else if (roll < 80) c = CMD_GET;
      else                c = CMD_SEARCH;
    end
    // mostly valid positions, some right at the count, the rest anywhere
    roll = $urandom_range(99);
    if (roll < 60 && stack_fill > 0)                 ix = POS_W'($urandom_range(stack_fill - 1));
    else if (roll < 70 && stack_fill < STACK_DEPTH)  ix = POS_W'(stack_fill);
    else                                             ix = POS_W'($urandom_range(63));
    return mk_req(c, pick_word(), ix);
  endfunction

  // offer one request beat, record its expected result once accepted
  task automatic send_req(in_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_q.push_back(stack_predict(b));
  endtask

  // drop valid and wait until every expected result beat is in
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls, or a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result beat: status %0d data %0d found_index %0d",
               out_beat.status, out_beat.data, out_beat.found_index);
        err_count++;
      end else begin
        out_beat_t exp_res;
        exp_res = result_q.pop_front();
        if (out_beat.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_beat.status);
          err_count++;
        end
        if (out_beat.data !== exp_res.data) begin
          $error("data: expected %0d, got %0d", exp_res.data, out_beat.data);
          err_count++;
        end
        if (out_beat.found_index !== exp_res.found_index) begin
          $error("found_index: expected %0d, got %0d",
                 exp_res.found_index, out_beat.found_index);
          err_count++;
        end
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // pop, get and search against an empty stack
  task automatic test_empty_stack();
    send_req(mk_req(CMD_POP, 32'sh7fff_ffff, 6'h3f));
    send_req(mk_req(CMD_GET, '0, '0));
    send_req(mk_req(CMD_GET, -32'sd1, 6'h3f));
    send_req(mk_req(CMD_SEARCH, '0, '0));
  endtask

  // extreme words, duplicates, bounds of get and search
  task automatic test_push_get_search();
    send_req(mk_req(CMD_PUSH, 32'sh8000_0000, 6'h3f));
    send_req(mk_req(CMD_PUSH, 32'sh7fff_ffff, '0));
    send_req(mk_req(CMD_PUSH, '0, 6'h2a));
    send_req(mk_req(CMD_PUSH, -32'sd1, 6'h15));
    send_req(mk_req(CMD_PUSH, 32'sd5, '0));
    send_req(mk_req(CMD_PUSH, 32'sd5, '0));
    send_req(mk_req(CMD_GET, 32'sh5555_5555, 6'd0));
    send_req(mk_req(CMD_GET, 32'shaaaa_aaaa, 6'd5));
    // index equal to the count, then far beyond it
    send_req(mk_req(CMD_GET, '0, 6'd6));
    send_req(mk_req(CMD_GET, '0, 6'h3f));
    // duplicate key: lowest position wins
    send_req(mk_req(CMD_SEARCH, 32'sd5, 6'h3f));
    send_req(mk_req(CMD_SEARCH, -32'sd1, '0));
    send_req(mk_req(CMD_SEARCH, 32'sh8000_0000, '0));
    send_req(mk_req(CMD_SEARCH, 32'sd12345, '0));
  endtask

  // pops come back in reverse order, then one more on empty
  task automatic test_pop_order();
    repeat (7) send_req(mk_req(CMD_POP, $urandom, POS_W'($urandom_range(63))));
  endtask

  // fill to the limit, refused push, top and bottom reads, then drain
  task automatic test_fill_to_full();
    while (stack_fill < STACK_DEPTH) send_req(mk_req(CMD_PUSH, $urandom, '0));
    send_req(mk_req(CMD_PUSH, $urandom, '0));
    send_req(mk_req(CMD_GET, '0, POS_W'(STACK_DEPTH - 1)));
    send_req(mk_req(CMD_SEARCH, stack_mem[STACK_DEPTH - 1], '0));
    send_req(mk_req(CMD_SEARCH, stack_mem[0], '0));
    while (stack_fill > 0) send_req(mk_req(CMD_POP, '0, '0));
    send_req(mk_req(CMD_POP, '0, '0));
  endtask

  // receiver holds off while requests keep coming, block must back up
  task automatic test_output_stall();
    wait_drain();
    hold_left = 300;
    repeat (24) send_req(make_random_req());
    wait_drain();
  endtask

  // random traffic; the trend flag sweeps the fill level up and down
  task automatic test_random(int n_items);
    repeat (n_items) begin
      if (stack_fill == STACK_DEPTH && $urandom_range(7) == 0)  grow = 1'b0;
      else if (stack_fill == 0 && $urandom_range(7) == 0)      grow = 1'b1;
      else if ($urandom_range(99) == 0)                        grow = !grow;
      send_req(make_random_req());
    end
    wait_drain();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_beat  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 74;
    test_empty_stack();
    test_push_get_search();
    test_pop_order();
    test_fill_to_full();
    test_output_stall();
    test_random(350);

    send_idle_pct = 74;
    recv_idle_pct = 27;
    test_random(350);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random(350);

    // allow for a stray late beat from a full-depth search
    repeat (STACK_DEPTH + 20) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[bounded_stack_with_search.f]
rtl/core/bsws_pkg.sv
rtl/core/bsws_ctrl.sv
rtl/core/bsws_dp.sv
rtl/core/bounded_stack_with_search.sv
test/tb.sv
